// File: rtl/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared widths, codes, coefficients and helpers of the RGB to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  localparam int PIXEL_W    = 32;
  localparam int ADDR_W     = 25;
  localparam int SAMPLE_W   = 8;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 12;
  localparam int LUMA_W     = 24;
  localparam int CHROMA_W   = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SIZE_W     = 2 * DIM_W;
  localparam int MATH_W     = 18;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  typedef enum logic [1:0] {
    COMP_Y = 2'd0,
    COMP_U = 2'd1,
    COMP_V = 2'd2
  } comp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PLANAR       = 3'd2,
    CFG_RED_OFFSET   = 3'd3,
    CFG_GREEN_OFFSET = 3'd4,
    CFG_BLUE_OFFSET  = 3'd5
  } cfg_reg_t;

  // bt.601 integer coefficients
  localparam logic signed [MATH_W-1:0] KY_R  =  18'sd66;
  localparam logic signed [MATH_W-1:0] KY_G  =  18'sd129;
  localparam logic signed [MATH_W-1:0] KY_B  =  18'sd25;
  localparam logic signed [MATH_W-1:0] KU_R  = -18'sd38;
  localparam logic signed [MATH_W-1:0] KU_G  = -18'sd74;
  localparam logic signed [MATH_W-1:0] KU_B  =  18'sd112;
  localparam logic signed [MATH_W-1:0] KV_R  =  18'sd112;
  localparam logic signed [MATH_W-1:0] KV_G  = -18'sd94;
  localparam logic signed [MATH_W-1:0] KV_B  = -18'sd18;
  localparam logic signed [MATH_W-1:0] ROUND_HALF = 18'sd128;
  localparam logic signed [MATH_W-1:0] Y_BIAS     = 18'sd16;
  localparam logic signed [MATH_W-1:0] C_BIAS     = 18'sd128;

  function automatic logic [SAMPLE_W-1:0] sat8(input logic signed [MATH_W-1:0] q);
    logic [SAMPLE_W-1:0] res;
    if (q < 0) begin
      res = '0;
    end else if (q > 18'sd255) begin
      res = '1;
    end else begin
      res = q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // zero reads as one, oversize saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: rtl/rgb2yuv_pixel_if.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pixel_if
// Valid/ready channel carrying one packed pixel word per request.
// ----------------------------------------------------------------------------
interface rgb2yuv_pixel_if import rgb2yuv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

// File: rtl/rgb2yuv_sample_if.sv
// ----------------------------------------------------------------------------
// rgb2yuv_sample_if
// Valid/ready channel carrying one addressed Y, U or V sample write.
// ----------------------------------------------------------------------------
interface rgb2yuv_sample_if import rgb2yuv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   sample_address;
  logic [SAMPLE_W-1:0] sample_value;
  logic [1:0]          component;
  logic                last_of_pixel;
  logic                frame_done;

  modport source (output valid, output sample_address, output sample_value,
                  output component, output last_of_pixel, output frame_done,
                  input ready);
  modport sink   (input valid, input sample_address, input sample_value,
                  input component, input last_of_pixel, input frame_done,
                  output ready);
endinterface

// File: rtl/rgb2yuv_csc.sv
// ----------------------------------------------------------------------------
// rgb2yuv_csc
// BT.601 color space conversion of one RGB triple to clamped 8-bit Y, U, V.
// ----------------------------------------------------------------------------
module rgb2yuv_csc import rgb2yuv_pkg::*; (
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic [SAMPLE_W-1:0] y_value,
  output logic [SAMPLE_W-1:0] u_value,
  output logic [SAMPLE_W-1:0] v_value
);

  logic signed [MATH_W-1:0] rs, gs, bs;
  logic signed [MATH_W-1:0] y_sum, u_sum, v_sum;
  logic signed [MATH_W-1:0] y_q, u_q, v_q;

  always_comb begin
    rs = $signed({10'd0, red});
    gs = $signed({10'd0, green});
    bs = $signed({10'd0, blue});
    y_sum = KY_R * rs + KY_G * gs + KY_B * bs + ROUND_HALF;
    u_sum = KU_R * rs + KU_G * gs + KU_B * bs + ROUND_HALF;
    v_sum = KV_R * rs + KV_G * gs + KV_B * bs + ROUND_HALF;
    // arithmetic shift gives floor division by 256
    y_q = (y_sum >>> 8) + Y_BIAS;
    u_q = (u_sum >>> 8) + C_BIAS;
    v_q = (v_sum >>> 8) + C_BIAS;
    y_value = sat8(y_q);
    u_value = sat8(u_q);
    v_value = sat8(v_q);
  end

endmodule

// File: rtl/rgb2yuv_to_yuv420_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_unit
// Converts a raster stream of packed RGB pixels into addressed BT.601 YUV
// 4:2:0 sample writes. Every pixel gives a luma write; pixels on an even row
// and an even column then give a U write and a V write. A pixel is taken
// into an input register when it arrives, converted in one pass and held in
// a result register that shows its writes one per cycle while the output
// port is ready. The output port is the only limit: with ready held high, a
// new pixel is accepted in every cycle that the result register frees. From
// acceptance a pixel passes the input register and then the result register
// before its first write. Chroma goes interleaved after the luma plane or, in
// planar mode, to a U plane after luma and a V plane a quarter frame further
// on. The user must write registers only between frames or while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_unit import rgb2yuv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rgb2yuv_pixel_if.sink         pixel_in,
  rgb2yuv_sample_if.source      sample_out
);

  // configuration
  logic [DIM_W-1:0] frame_width, frame_height;
  logic             planar_output;
  logic [1:0]       red_byte_offset, green_byte_offset, blue_byte_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= RESET_WIDTH;
      frame_height      <= RESET_HEIGHT;
      planar_output     <= 1'b0;
      red_byte_offset   <= 2'd0;
      green_byte_offset <= 2'd1;
      blue_byte_offset  <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width       <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height      <= cfg_data[DIM_W-1:0];
        CFG_PLANAR:       planar_output     <= cfg_data[0];
        CFG_RED_OFFSET:   red_byte_offset   <= cfg_data[1:0];
        CFG_GREEN_OFFSET: green_byte_offset <= cfg_data[1:0];
        CFG_BLUE_OFFSET:  blue_byte_offset  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] width_eff, height_eff;
  assign width_eff  = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign height_eff = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));

  // position counters, advanced when a request is accepted
  logic [CNT_W-1:0]    column_count, row_count;
  logic [LUMA_W-1:0]   luma_count;
  logic [CHROMA_W-1:0] chroma_count;
  logic                pix_take, acc_chroma, acc_row_end, acc_done;

  assign pix_take    = pixel_in.valid && pixel_in.ready;
  assign acc_chroma  = !row_count[0] && !column_count[0];
  assign acc_row_end = ({1'b0, column_count} + DIM_W'(1)) >= width_eff;
  assign acc_done    = acc_row_end && (({1'b0, row_count} + DIM_W'(1)) >= height_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      luma_count   <= '0;
      chroma_count <= '0;
    end else if (pix_take) begin
      if (acc_done) begin
        column_count <= '0;
        row_count    <= '0;
        luma_count   <= '0;
        chroma_count <= '0;
      end else begin
        luma_count <= luma_count + LUMA_W'(1);
        if (acc_chroma) begin
          chroma_count <= chroma_count + CHROMA_W'(1);
        end
        if (acc_row_end) begin
          column_count <= '0;
          row_count    <= row_count + CNT_W'(1);
        end else begin
          column_count <= column_count + CNT_W'(1);
        end
      end
    end
  end

  // input register
  logic                a_valid;
  logic [PIXEL_W-1:0]  a_pixel;
  logic [LUMA_W-1:0]   a_luma;
  logic [CHROMA_W-1:0] a_chroma_cnt;
  logic                a_chroma, a_done;

  // result register
  logic                b_valid;
  logic [SAMPLE_W-1:0] b_y, b_u, b_v;
  logic [ADDR_W-1:0]   b_y_addr, b_u_addr, b_v_addr;
  logic                b_chroma, b_done;
  comp_t               b_idx;

  logic out_take, b_last, b_free, a_move;

  assign out_take = sample_out.valid && sample_out.ready;
  assign b_last   = (b_idx == COMP_V) || ((b_idx == COMP_Y) && !b_chroma);
  assign b_free   = !b_valid || (out_take && b_last);
  assign a_move   = a_valid && b_free;
  assign pixel_in.ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix_take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      a_pixel      <= pixel_in.pixel_word;
      a_luma       <= luma_count;
      a_chroma_cnt <= chroma_count;
      a_chroma     <= acc_chroma;
      a_done       <= acc_done;
    end
  end

  // conversion and addressing of the pixel in the input register
  logic [SAMPLE_W-1:0] y_value, u_value, v_value;
  logic [SIZE_W-1:0]   size_full;
  logic [ADDR_W-1:0]   size_addr, chroma_ext, u_addr, v_addr;

  rgb2yuv_csc u_csc (
    .red     (a_pixel[{red_byte_offset, 3'b000} +: 8]),
    .green   (a_pixel[{green_byte_offset, 3'b000} +: 8]),
    .blue    (a_pixel[{blue_byte_offset, 3'b000} +: 8]),
    .y_value (y_value),
    .u_value (u_value),
    .v_value (v_value)
  );

  always_comb begin
    size_full  = SIZE_W'(width_eff) * SIZE_W'(height_eff);
    size_addr  = size_full[ADDR_W-1:0];
    chroma_ext = ADDR_W'(a_chroma_cnt);
    if (planar_output) begin
      u_addr = size_addr + chroma_ext;
      v_addr = size_addr + (size_addr >> 2) + chroma_ext;
    end else begin
      u_addr = size_addr + {chroma_ext[ADDR_W-2:0], 1'b0};
      v_addr = u_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= COMP_Y;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_idx   <= COMP_Y;
    end else if (out_take) begin
      if (b_last) begin
        b_valid <= 1'b0;
      end else if (b_idx == COMP_Y) begin
        b_idx <= COMP_U;
      end else begin
        b_idx <= COMP_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_y      <= y_value;
      b_u      <= u_value;
      b_v      <= v_value;
      b_y_addr <= ADDR_W'(a_luma);
      b_u_addr <= u_addr;
      b_v_addr <= v_addr;
      b_chroma <= a_chroma;
      b_done   <= a_done;
    end
  end

  // one write per cycle out of the result register while the output is ready
  always_comb begin
    sample_out.valid         = b_valid;
    sample_out.component     = b_idx;
    sample_out.last_of_pixel = b_last;
    sample_out.frame_done    = b_done;
    case (b_idx)
      COMP_U: begin
        sample_out.sample_address = b_u_addr;
        sample_out.sample_value   = b_u;
      end
      COMP_V: begin
        sample_out.sample_address = b_v_addr;
        sample_out.sample_value   = b_v;
      end
      default: begin
        sample_out.sample_address = b_y_addr;
        sample_out.sample_value   = b_y;
      end
    endcase
  end

  // a chroma site luma write is followed by its U write
  a_y_then_u: assert property (@(posedge clk) disable iff (rst)
    out_take && (b_idx == COMP_Y) && !b_last |=> b_valid && (b_idx == COMP_U))
    else $error("chroma site luma write not followed by U write");

  // every U write is followed by its V write
  a_u_then_v: assert property (@(posedge clk) disable iff (rst)
    out_take && (b_idx == COMP_U) |=> b_valid && (b_idx == COMP_V))
    else $error("U write not followed by V write");

  // the last pixel of a frame restarts every counter
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    pix_take && acc_done |=> (luma_count == '0) && (chroma_count == '0)
                             && (column_count == '0) && (row_count == '0))
    else $error("counters not cleared at end of frame");

endmodule

// File: verif/rgb_to_yuv420_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_unit_tb
// Streams packed RGB pixels through the converter under several frame sizes,
// byte layouts and chroma layouts. Every pixel request is run through a local
// BT.601 model of the raster counters and the sample math. Each sample write
// that comes out is checked against the oldest predicted write. Both ports
// idle and stall at random.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2yuv_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PIXELS  = 80;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] value;
    comp_t               comp;
    logic                last;
    logic                done;
  } sample_write_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  feed_valid   = 1'b0;
  logic [PIXEL_W-1:0]    feed_word    = '0;
  logic                  drain_ready  = 1'b0;
  logic                  pixel_taken  = 1'b0;

  rgb2yuv_pixel_if  pix ();
  rgb2yuv_sample_if smp ();

  assign pix.valid      = feed_valid;
  assign pix.pixel_word = feed_word;
  assign smp.ready      = drain_ready;

  rgb_to_yuv420_converter_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pix),
    .sample_out (smp)
  );

  // register copies and raster state of the local model
  logic [DIM_W-1:0] width_reg   = RESET_WIDTH;
  logic [DIM_W-1:0] height_reg  = RESET_HEIGHT;
  logic             planar_reg  = 1'b0;
  logic [1:0]       red_sel     = 2'd0;
  logic [1:0]       green_sel   = 2'd1;
  logic [1:0]       blue_sel    = 2'd2;
  int               col_pos     = 0;
  int               row_pos     = 0;
  int               luma_idx    = 0;
  int               chroma_idx  = 0;

  logic [PIXEL_W-1:0] pixel_queue[$];
  sample_write_t      sample_expect_q[$];
  int                 mismatch_count = 0;
  int                 feed_gap       = 0;
  int                 drain_hold     = 0;
  int                 idle_cycles    = 0;
  bit                 steady         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int next_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // floor shift, bias, clamp to a byte
  function automatic logic [SAMPLE_W-1:0] scale_sample(input int t, input int bias);
    int q;
    q = (t >>> 8) + bias;
    if (q < 0) return '0;
    if (q > 255) return '1;
    return SAMPLE_W'(q);
  endfunction

  function automatic void queue_write(input int addr, input logic [SAMPLE_W-1:0] value,
                                      input comp_t comp, input logic last,
                                      input logic done);
    sample_write_t wr;
    wr.addr  = ADDR_W'(addr);
    wr.value = value;
    wr.comp  = comp;
    wr.last  = last;
    wr.done  = done;
    sample_expect_q.push_back(wr);
  endfunction

  task automatic predict_pixel(input logic [PIXEL_W-1:0] word);
    int w, h, size, r, g, b, ua, va;
    logic site, row_end, frame_end;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    size = w * h;
    r = word[red_sel*8 +: 8];
    g = word[green_sel*8 +: 8];
    b = word[blue_sel*8 +: 8];
    site = (row_pos % 2 == 0) && (col_pos % 2 == 0);
    row_end = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);

    queue_write(luma_idx, scale_sample(66 * r + 129 * g + 25 * b + 128, 16),
                COMP_Y, !site, frame_end);
    if (site) begin
      if (planar_reg) begin
        ua = size + chroma_idx;
        va = size + size / 4 + chroma_idx;
      end else begin
        ua = size + 2 * chroma_idx;
        va = ua + 1;
      end
      queue_write(ua, scale_sample(-38 * r - 74 * g + 112 * b + 128, 128),
                  COMP_U, 1'b0, frame_end);
      queue_write(va, scale_sample(112 * r - 94 * g - 18 * b + 128, 128),
                  COMP_V, 1'b1, frame_end);
    end

    if (frame_end) begin
      col_pos = 0;
      row_pos = 0;
      luma_idx = 0;
      chroma_idx = 0;
    end else begin
      luma_idx = (luma_idx + 1) & 32'h0FFF_FFFF;
      if (site) chroma_idx = (chroma_idx + 1) & 32'h0FFF_FFFF;
      if (row_end) begin
        col_pos = 0;
        row_pos = row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    end
  endtask

  // pixel requests: hold until taken, then an optional gap
  always @(negedge clk) begin
    if (rst) begin
      feed_valid <= 1'b0;
      feed_gap = 0;
    end else if (!feed_valid || pixel_taken) begin
      if (feed_gap > 0) begin
        feed_valid <= 1'b0;
        feed_gap = feed_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        feed_word  <= pixel_queue.pop_front();
        feed_valid <= 1'b1;
        feed_gap = next_gap();
      end else begin
        feed_valid <= 1'b0;
      end
    end
  end

  // sample side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      drain_ready <= 1'b0;
      drain_hold = 0;
    end else if (drain_hold > 0) begin
      drain_ready <= 1'b0;
      drain_hold = drain_hold - 1;
    end else begin
      drain_hold = next_gap();
      if (drain_hold == 0) begin
        drain_ready <= 1'b1;
      end else begin
        drain_ready <= 1'b0;
        drain_hold = drain_hold - 1;
      end
    end
  end

  // check writes first, then predict the pixel taken on this edge
  always @(posedge clk) begin
    sample_write_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= pix.valid && pix.ready;
      if (smp.valid && smp.ready) begin
        if (sample_expect_q.size() == 0) begin
          $error("unexpected sample write: address %0h value %0h component %0d",
                 smp.sample_address, smp.sample_value, smp.component);
          mismatch_count++;
        end else begin
          want = sample_expect_q.pop_front();
          if (smp.sample_address !== want.addr) begin
            $error("sample_address: expected %0h, got %0h", want.addr, smp.sample_address);
            mismatch_count++;
          end
          if (smp.sample_value !== want.value) begin
            $error("sample_value: expected %0h, got %0h", want.value, smp.sample_value);
            mismatch_count++;
          end
          if (smp.component !== want.comp) begin
            $error("component: expected %0d, got %0d", want.comp, smp.component);
            mismatch_count++;
          end
          if (smp.last_of_pixel !== want.last) begin
            $error("last_of_pixel: expected %0b, got %0b", want.last, smp.last_of_pixel);
            mismatch_count++;
          end
          if (smp.frame_done !== want.done) begin
            $error("frame_done: expected %0b, got %0b", want.done, smp.frame_done);
            mismatch_count++;
          end
        end
      end
      if (pix.valid && pix.ready) predict_pixel(pix.pixel_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (smp.valid && smp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // called at a falling edge while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg  = data;
      CFG_FRAME_HEIGHT: height_reg = data;
      CFG_PLANAR:       planar_reg = data[0];
      CFG_RED_OFFSET:   red_sel    = data[1:0];
      CFG_GREEN_OFFSET: green_sel  = data[1:0];
      CFG_BLUE_OFFSET:  blue_sel   = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || feed_valid || sample_expect_q.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 6));
  endfunction

  initial begin
    int sent;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset layout, single byte extremes and the unused byte
    pixel_queue.push_back(32'h0000_0000);
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h0000_00FF);
    pixel_queue.push_back(32'h0000_FF00);
    pixel_queue.push_back(32'h00FF_0000);
    pixel_queue.push_back(32'hFF00_0000);
    wait_idle();

    // tiny planar frame with the byte order turned around
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
    write_reg(CFG_PLANAR, CFG_DATA_W'(1));
    write_reg(CFG_RED_OFFSET, CFG_DATA_W'(3));
    write_reg(CFG_GREEN_OFFSET, CFG_DATA_W'(2));
    write_reg(CFG_BLUE_OFFSET, CFG_DATA_W'(1));
    pixel_queue.push_back(32'hFF00_0000);
    pixel_queue.push_back(32'h00FF_0000);
    pixel_queue.push_back(32'h0000_FF00);
    pixel_queue.push_back(32'hFFFF_FF00);
    pixel_queue.push_back(32'h1234_5678);
    wait_idle();

    // odd width, one row, interleaved
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
    write_reg(CFG_PLANAR, '0);
    for (int k = 0; k < 4; k++) pixel_queue.push_back($urandom);
    wait_idle();

    // zero sizes read as one pixel
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    pixel_queue.push_back(32'h00FF_FFFF);
    pixel_queue.push_back($urandom);
    wait_idle();

    // oversize saturates, planar addresses near the top
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, '1);
    write_reg(CFG_PLANAR, '1);
    // unmapped indexes must change nothing
    for (int idx = int'(CFG_BLUE_OFFSET) + 1; idx < 2 ** CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), '1);
    for (int k = 0; k < 3; k++) pixel_queue.push_back($urandom);
    wait_idle();

    // random phases; frames are left unfinished so sizes also shrink mid frame
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FRAME_WIDTH, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FRAME_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) != 0) write_reg(CFG_PLANAR, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_reg(CFG_RED_OFFSET, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_reg(CFG_GREEN_OFFSET, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_reg(CFG_BLUE_OFFSET, CFG_DATA_W'($urandom));
      n = $urandom_range(8, 20);
      for (int k = 0; k < n; k++) pixel_queue.push_back($urandom);
      sent += n;
      wait_idle();
    end

    steady = 1'b0;
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
